// File: rtl/core/oust_pkg.sv
// shared types, constants and codes of the ordered unique-key table
`default_nettype none
package oust_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 6;

    // request opcodes; the spare code behaves as a lookup
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PRESENT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;
        logic valid;
        logic load_key;
        logic shift;
    } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/oust_cell.sv
// one table cell: holds a key, compares it, loads or takes the neighbor's key
`default_nettype none
module oust_cell
    import oust_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [KEY_W-1:0] req_key,
    input  logic [KEY_W-1:0] nbr_key,
    output logic [KEY_W-1:0] key_out,
    output logic             match
);

    logic [KEY_W-1:0] key_reg;
    logic             match_reg;
    logic             match_next;

    assign match_next = ctl.valid && (key_reg == req_key);

    // key storage, no reset: only cells below the count are ever compared
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            key_reg <= nbr_key;
        end
        else if (ctl.load_key)
        begin
            key_reg <= req_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            match_reg <= match_next;
        end
    end

    assign key_out = key_reg;
    assign match   = match_reg;

endmodule
`default_nettype wire

// File: rtl/core/ordered_unique_set_table_unit.sv
// top level of the ordered unique-key table: sequencer and row of cells
`default_nettype none
// usage
// - requests: drive opcode and key and raise start; the request is taken at
//   a rising edge with start high and busy low
// - opcodes: lookup, add if absent (appended after the last entry), remove
//   if present (later entries move down one place, order is kept)
// - each cell of the row holds one key and compares it with the request key
//   in parallel, so there is no walk over the table
// - timing: a compare state in which all cells compare, then an update
//   state that encodes the hit position and updates the row; done rises
//   at the edge that ends the update state, stays high for exactly one
//   cycle and the result is taken at the edge ending it
// - requests are taken only in idle, so a new one waits for the last;
//   idle is reached again in the result cycle, so busy is low while done
//   is high and the next request may be taken at the edge ending it
// - status, found, position and entry_count are valid only while done is
//   high; the receiver cannot hold a result off and must take it then
// - reset: the table is empty (count zero), the block is idle; cell keys
//   are not cleared, cells at or above the count are never compared
// - an add of a new key to a full table reports full and leaves it unchanged
module ordered_unique_set_table_unit
    import oust_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   opcode,
    input  logic [KEY_W-1:0]  key,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic              found,
    output logic [POS_W-1:0]  position,
    output logic [CNT_W-1:0]  entry_count
);

    state_t state_reg;
    state_t state_next;

    // captured request
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;

    // table count and result registers
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    logic              done_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic              found_reg;
    logic              found_next;
    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  position_next;

    // sequencer outputs
    logic accept;
    logic cmp_en;
    logic upd_en;

    // row signals
    logic [KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    cell_ctl_t cell_ctl [CAPACITY];

    // update decisions
    logic             hit;
    logic [IDX_W-1:0] hit_pos;
    logic             full;
    logic             do_add;
    logic             do_remove;

    assign accept = start && !busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy   = 1'b1;
        cmp_en = 1'b0;
        upd_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_CMP:
            begin
                cmp_en = 1'b1;
            end
            ST_UPD:
            begin
                upd_en = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
    end

    // keys are unique, so at most one cell matches: the position is an or
    // of the indexes of matching cells
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    assign hit       = |match_vec;
    assign full      = (count_reg == CAP_CNT);
    assign do_add    = upd_en && (op_reg == OP_ADD) && !hit && !full;
    assign do_remove = upd_en && (op_reg == OP_REMOVE) && hit;

    // result and count
    always_comb
    begin
        done_next     = upd_en;
        count_next    = count_reg;
        found_next    = hit;
        position_next = POS_W'(hit_pos);
        status_next   = hit ? STAT_DONE : STAT_ABSENT;
        case (op_reg)
            OP_ADD:
            begin
                if (hit)
                begin
                    status_next = STAT_PRESENT;
                end
                else if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    status_next = STAT_DONE;
                end
            end
            default:
            begin
                status_next = hit ? STAT_DONE : STAT_ABSENT;
            end
        endcase
        if (do_add)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_en)
        begin
            status_reg   <= status_next;
            found_reg    <= found_next;
            position_reg <= position_next;
        end
    end

    // row of cells; a remove moves every cell from the hit onward down one
    // place, an add loads the cell at the current count
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] CELL_CNT = CNT_W'(i);
        localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(i);
        logic [KEY_W-1:0] nbr_key;

        if (i == CAPACITY - 1)
        begin : g_last
            assign nbr_key = cell_key[i];
        end
        else
        begin : g_mid
            assign nbr_key = cell_key[i+1];
        end

        assign cell_ctl[i].cmp_en   = cmp_en;
        assign cell_ctl[i].valid    = (CELL_CNT < count_reg);
        assign cell_ctl[i].load_key = do_add && (CELL_CNT == count_reg);
        assign cell_ctl[i].shift    = do_remove && (CELL_IDX >= hit_pos);

        oust_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cell_ctl[i]),
            .req_key (key_reg),
            .nbr_key (nbr_key),
            .key_out (cell_key[i]),
            .match   (match_vec[i])
        );
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_count = count_reg;

endmodule
`default_nettype wire

// File: rtl/core/oust_checker.sv
// port-level checker of the ordered unique-key table and its bind
`default_nettype none
module oust_checker
    import oust_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire logic [STAT_W-1:0] status,
    input wire logic              found,
    input wire logic [POS_W-1:0]  position,
    input wire logic [CNT_W-1:0]  entry_count
);

    // a taken request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // the result of a taken request is signalled by a done pulse
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result missing three cycles after request");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (position == '0))
        else $error("position nonzero on a miss");

    // already present implies found; full implies a full table and no hit
    a_status_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_PRESENT)) |-> found)
        else $error("already present without found");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_FULL)) |-> (!found && (entry_count == CAP_CNT)))
        else $error("full status with table not full");

endmodule

bind ordered_unique_set_table_unit oust_checker u_oust_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .found       (found),
    .position    (position),
    .entry_count (entry_count)
);
`default_nettype wire
